// ===== hw/rtl/nbt_pkg.sv =====
// Shared types, constants and helpers for the neighbor table.
package nbt_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF   = 1'd1;

    localparam logic [31:0] EXPIRY_RESET = 32'd60000;
    localparam logic [7:0]  LEAF_RESET   = 8'd0;

    typedef enum logic [3:0] {
        OP_BEACON   = 4'd0,
        OP_ANNOUNCE = 4'd1,
        OP_ROUTE    = 4'd2,
        OP_MARK     = 4'd3,
        OP_EXPIRE   = 4'd4,
        OP_CLR_MARK = 4'd5,
        OP_CLEAR    = 4'd6,
        OP_HARVEST  = 4'd7,
        OP_LEAF     = 4'd8,
        OP_MULTIHOP = 4'd9,
        OP_COUNT    = 4'd10,
        OP_READ     = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic [47:0]        node_key;
        logic [7:0]         node_role;
        logic [7:0]         picture_count;
        logic signed [7:0]  signal_dbm;
        logic [31:0]        ip_addr;
        logic [47:0]        relay_key;
        logic [7:0]         hops;
        logic [31:0]        time_now_ms;
        logic [3:0]         slot_select;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic [3:0]         slot;
        logic [47:0]        out_key;
        logic [7:0]         out_role;
        logic [7:0]         out_pictures;
        logic signed [7:0]  out_signal;
        logic [31:0]        out_ip;
        logic [7:0]         out_hops;
        logic [47:0]        out_relay;
        logic               out_route_known;
        logic               out_harvested;
        logic [4:0]         live_count;
    } out_t;

    // One slot as kept in the entry memory.
    typedef struct packed {
        logic [47:0]        key;
        logic [7:0]         role;
        logic [7:0]         pictures;
        logic signed [7:0]  signal;
        logic [31:0]        seen_ms;
        logic [31:0]        ip;
        logic [7:0]         hops;
        logic [47:0]        relay;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              match_found;
        logic [SLOT_W-1:0] match_slot;
        entry_t            match_rec;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic [SLOT_W-1:0] weak_slot;
        logic              harv_found;
        logic [SLOT_W-1:0] harv_slot;
        logic              leaf_found;
        logic [SLOT_W-1:0] leaf_slot;
    } scan_res_t;

    function automatic logic [CNT_W-1:0] count_ones(input logic [SLOT_COUNT-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/nbt_ram.sv =====
// Simple dual-port RAM with registered read data.
module nbt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/nbt_scan.sv =====
// Per-slot compare and select accumulators for the table sweep.
module nbt_scan (
    input  logic                       aclk,
    input  logic                       clear,
    input  logic                       el_vld,
    input  logic [nbt_pkg::SLOT_W-1:0] el_idx,
    input  nbt_pkg::entry_t            el_rec,
    input  logic                       el_active,
    input  logic                       el_harv,
    input  logic [47:0]                key,
    input  logic [7:0]                 leaf_code,
    input  logic [31:0]                now_ms,
    input  logic [31:0]                limit_ms,
    output nbt_pkg::scan_res_t         res,
    output logic                       expire_hit
);
    import nbt_pkg::*;

    scan_res_t         res_reg, res_next;
    logic              weak_found_reg, weak_found_next;
    logic signed [7:0] weak_sig_reg, weak_sig_next;
    logic signed [7:0] harv_sig_reg, harv_sig_next;
    logic signed [7:0] leaf_sig_reg, leaf_sig_next;
    logic [47:0]       leaf_key_reg, leaf_key_next;
    logic [31:0]       age;

    assign age        = now_ms - el_rec.seen_ms;
    assign expire_hit = el_vld && el_active && (age > limit_ms);
    assign res        = res_reg;

    always_comb begin
        res_next        = res_reg;
        weak_found_next = weak_found_reg;
        weak_sig_next   = weak_sig_reg;
        harv_sig_next   = harv_sig_reg;
        leaf_sig_next   = leaf_sig_reg;
        leaf_key_next   = leaf_key_reg;
        if (clear) begin
            res_next.match_found = 1'b0;
            res_next.free_found  = 1'b0;
            res_next.harv_found  = 1'b0;
            res_next.leaf_found  = 1'b0;
            weak_found_next      = 1'b0;
        end else if (el_vld) begin
            // First active match wins.
            if (!res_reg.match_found && el_active && el_rec.key == key) begin
                res_next.match_found = 1'b1;
                res_next.match_slot  = el_idx;
                res_next.match_rec   = el_rec;
            end
            if (!res_reg.free_found && !el_active) begin
                res_next.free_found = 1'b1;
                res_next.free_slot  = el_idx;
            end
            // Weakest is only used when every slot is active.
            if (!weak_found_reg || el_rec.signal < weak_sig_reg) begin
                weak_found_next    = 1'b1;
                weak_sig_next      = el_rec.signal;
                res_next.weak_slot = el_idx;
            end
            if (el_active && !el_harv &&
                (!res_reg.harv_found || el_rec.signal > harv_sig_reg)) begin
                res_next.harv_found = 1'b1;
                res_next.harv_slot  = el_idx;
                harv_sig_next       = el_rec.signal;
            end
            if (el_active && el_rec.role == leaf_code &&
                (!res_reg.leaf_found || el_rec.signal > leaf_sig_reg ||
                 (el_rec.signal == leaf_sig_reg && el_rec.key > leaf_key_reg))) begin
                res_next.leaf_found = 1'b1;
                res_next.leaf_slot  = el_idx;
                leaf_sig_next       = el_rec.signal;
                leaf_key_next       = el_rec.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg        <= res_next;
        weak_found_reg <= weak_found_next;
        weak_sig_reg   <= weak_sig_next;
        harv_sig_reg   <= harv_sig_next;
        leaf_sig_reg   <= leaf_sig_next;
        leaf_key_reg   <= leaf_key_next;
    end
endmodule

// ===== hw/rtl/neighbor_table_rssi_replace_core.sv =====
// Neighbor table top level: sequencer, slot flags and entry memory.
// Requests that sweep the table pass through scan, drain, apply, fetch and load;
//   clear, clear marks, count and read slot go straight to apply, fetch and load.
// Flow: one request at a time; a new request is taken only once the sequencer
//   is back in idle, which a stalled output register can delay. The sweep reads
//   one memory entry per cycle through the single read port, which sets the
//   length of a sweep.
// Reset: flags clear at once, control and configuration registers return to
//   defaults; the entry memory needs no clearing since inactive slots never reach a result.
module neighbor_table_rssi_replace_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  nbt_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output nbt_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [nbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nbt_pkg::*;

    state_t            state_reg, state_next;
    in_t               req_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rvld_reg;
    logic [SLOT_W-1:0] ridx_reg;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic              selv_reg, selv_next;
    logic              ok_reg, ok_next;
    logic [31:0]       expiry_reg;
    logic [7:0]        leaf_reg;
    logic [SLOT_COUNT-1:0] active_reg, harv_reg, route_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    // memory port controls
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wrec;
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic [ENTRY_W-1:0] rdata;
    entry_t            rrec;

    scan_res_t         sres;
    logic              expire_hit;
    logic              scan_clear;
    logic              ins_new;
    logic [6:0]        sel_ext;
    logic              is_sweep;
    out_t              out_next;

    assign rrec    = entry_t'(rdata);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign sel_ext = 7'(req_reg.slot_select);

    always_comb begin
        case (s_data.operation) inside
            OP_BEACON, OP_ANNOUNCE, OP_ROUTE, OP_MARK, OP_EXPIRE,
            OP_HARVEST, OP_LEAF, OP_MULTIHOP: is_sweep = 1'b1;
            default:                          is_sweep = 1'b0;
        endcase
    end

    nbt_ram #(.DEPTH(SLOT_COUNT), .WIDTH(ENTRY_W)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (ENTRY_W'(wrec)),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    nbt_scan u_scan (
        .aclk       (aclk),
        .clear      (scan_clear),
        .el_vld     (rvld_reg),
        .el_idx     (ridx_reg),
        .el_rec     (rrec),
        .el_active  (active_reg[ridx_reg]),
        .el_harv    (harv_reg[ridx_reg]),
        .key        (req_reg.node_key),
        .leaf_code  (leaf_reg),
        .now_ms     (req_reg.time_now_ms),
        .limit_ms   (expiry_reg),
        .res        (sres),
        .expire_hit (expire_hit)
    );

    // Sequencer: next state, memory controls, selection.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        selv_next  = selv_reg;
        ok_next    = ok_reg;
        scan_clear = 1'b0;
        we         = 1'b0;
        waddr      = sel_reg;
        wrec       = sres.match_rec;
        re         = 1'b0;
        raddr      = cnt_reg[SLOT_W-1:0];
        ins_new    = 1'b0;
        out_next   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    scan_clear = 1'b1;
                    cnt_next   = '0;
                    state_next = is_sweep ? ST_SCAN : ST_APPLY;
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle, slot 0 upward.
                re       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SLOT_COUNT - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                selv_next  = 1'b0;
                ok_next    = 1'b0;
                state_next = ST_FETCH;
                case (req_reg.operation)
                    OP_BEACON, OP_ANNOUNCE: begin
                        selv_next = 1'b1;
                        we        = 1'b1;
                        if (sres.match_found) begin
                            sel_next      = sres.match_slot;
                            waddr         = sres.match_slot;
                            wrec.pictures = req_reg.picture_count;
                            wrec.seen_ms  = req_reg.time_now_ms;
                            if (req_reg.operation == OP_BEACON) begin
                                wrec.role = req_reg.node_role;
                                if (req_reg.signal_dbm > sres.match_rec.signal) begin
                                    wrec.signal = req_reg.signal_dbm;
                                end
                            end else begin
                                wrec.ip = req_reg.ip_addr;
                            end
                        end else begin
                            ins_new       = 1'b1;
                            ok_next       = 1'b1;
                            sel_next      = sres.free_found ? sres.free_slot : sres.weak_slot;
                            waddr         = sel_next;
                            wrec.key      = req_reg.node_key;
                            wrec.pictures = req_reg.picture_count;
                            wrec.seen_ms  = req_reg.time_now_ms;
                            wrec.hops     = 8'd1;
                            wrec.relay    = '0;
                            if (req_reg.operation == OP_BEACON) begin
                                wrec.role   = req_reg.node_role;
                                wrec.signal = req_reg.signal_dbm;
                                wrec.ip     = '0;
                            end else begin
                                wrec.role   = leaf_reg;
                                wrec.signal = '0;
                                wrec.ip     = req_reg.ip_addr;
                            end
                        end
                    end
                    OP_ROUTE: begin
                        selv_next  = sres.match_found;
                        ok_next    = sres.match_found;
                        sel_next   = sres.match_slot;
                        we         = sres.match_found;
                        waddr      = sres.match_slot;
                        wrec.hops  = req_reg.hops;
                        wrec.relay = req_reg.relay_key;
                    end
                    OP_MARK, OP_MULTIHOP: begin
                        selv_next = sres.match_found;
                        ok_next   = sres.match_found;
                        sel_next  = sres.match_slot;
                    end
                    OP_HARVEST: begin
                        selv_next = sres.harv_found;
                        ok_next   = sres.harv_found;
                        sel_next  = sres.harv_slot;
                    end
                    OP_LEAF: begin
                        selv_next = sres.leaf_found;
                        ok_next   = sres.leaf_found;
                        sel_next  = sres.leaf_slot;
                    end
                    OP_READ: begin
                        if (sel_ext < 7'(SLOT_COUNT) && active_reg[sel_ext[SLOT_W-1:0]]) begin
                            selv_next = 1'b1;
                            ok_next   = 1'b1;
                            sel_next  = sel_ext[SLOT_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FETCH: begin
                // Read back the selected slot after its update.
                re         = 1'b1;
                raddr      = sel_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                out_next.live_count = 5'(count_ones(active_reg));
                out_next.ok         = ok_reg;
                if (selv_reg) begin
                    out_next.slot            = 4'(sel_reg);
                    out_next.out_key         = rrec.key;
                    out_next.out_role        = rrec.role;
                    out_next.out_pictures    = rrec.pictures;
                    out_next.out_signal      = rrec.signal;
                    out_next.out_ip          = rrec.ip;
                    out_next.out_hops        = rrec.hops;
                    out_next.out_relay       = rrec.relay;
                    out_next.out_route_known = route_reg[sel_reg];
                    out_next.out_harvested   = harv_reg[sel_reg];
                    if (req_reg.operation == OP_MULTIHOP) begin
                        out_next.ok = route_reg[sel_reg] && (rrec.hops > 8'd1);
                    end
                end
                // Hold the result here until the output register frees up.
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rvld_reg  <= 1'b0;
            selv_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rvld_reg  <= (state_reg == ST_SCAN);
            selv_reg  <= selv_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg <= cnt_reg[SLOT_W-1:0];
        sel_reg  <= sel_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg <= EXPIRY_RESET;
            leaf_reg   <= LEAF_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EXPIRY: expiry_reg <= cfg_wdata;
                CFG_LEAF:   leaf_reg   <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Slot flags: active, harvested, route known.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            harv_reg   <= '0;
            route_reg  <= '0;
        end else begin
            // Drop stale entries as the sweep passes them.
            if (expire_hit && req_reg.operation == OP_EXPIRE) begin
                active_reg[ridx_reg] <= 1'b0;
            end
            if (state_reg == ST_APPLY) begin
                case (req_reg.operation)
                    OP_BEACON, OP_ANNOUNCE: begin
                        if (ins_new) begin
                            active_reg[sel_next] <= 1'b1;
                            harv_reg[sel_next]   <= 1'b0;
                            route_reg[sel_next]  <= 1'b0;
                        end else if (req_reg.operation == OP_ANNOUNCE) begin
                            harv_reg[sel_next] <= 1'b0;
                        end
                    end
                    OP_ROUTE: begin
                        if (sres.match_found) begin
                            route_reg[sres.match_slot] <= 1'b1;
                        end
                    end
                    OP_MARK: begin
                        if (sres.match_found) begin
                            harv_reg[sres.match_slot] <= 1'b1;
                        end
                    end
                    OP_CLR_MARK: begin
                        harv_reg <= '0;
                    end
                    OP_CLEAR: begin
                        active_reg <= '0;
                        harv_reg   <= '0;
                        route_reg  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: load on leaving the final state, drop on accept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_LOAD && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && (!m_valid_reg || m_ready)) begin
            m_data_reg <= out_next;
        end
    end

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.live_count <= 5'(SLOT_COUNT)))
        else $error("live count above slot count");

    a_scan_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("sweep left early");

    a_insert_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY && ins_new) |=> active_reg[sel_reg])
        else $error("inserted slot not active");

    a_no_result_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && !selv_reg) |-> (out_next.slot == 4'd0 && !out_next.ok))
        else $error("result without selected slot");
endmodule

// ===== test/nbt_checker.sv =====
// Neighbor table checker: table predictor, expected-result queue and comparison.
module nbt_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  nbt_pkg::in_t                   s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  nbt_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [nbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             outstanding
);
    import nbt_pkg::*;

    localparam int NSLOT = SLOT_COUNT;

    logic [31:0]       age_limit;
    logic [7:0]        leaf_code;
    logic              live   [NSLOT];
    logic              picked [NSLOT];
    logic [47:0]       t_key  [NSLOT];
    logic [7:0]        t_role [NSLOT];
    logic [7:0]        t_pics [NSLOT];
    logic signed [7:0] t_sig  [NSLOT];
    logic [31:0]       t_seen [NSLOT];
    logic [31:0]       t_ip   [NSLOT];
    logic [7:0]        t_hops [NSLOT];
    logic              t_rte  [NSLOT];
    logic [47:0]       t_relay[NSLOT];

    out_t expected_results[$];

    function void table_reset();
        age_limit = EXPIRY_RESET;
        leaf_code = LEAF_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            live[i] = 1'b0; picked[i] = 1'b0; t_key[i] = '0; t_role[i] = '0;
            t_pics[i] = '0; t_sig[i] = '0; t_seen[i] = '0; t_ip[i] = '0;
            t_hops[i] = 8'd1; t_rte[i] = 1'b0; t_relay[i] = '0;
        end
    endfunction

    function int lookup(logic [47:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (live[i] && t_key[i] == k) return i;
        return -1;
    endfunction

    // Free slot first, else the weakest one (lowest slot on ties).
    function int pick_victim();
        int w;
        w = -1;
        for (int i = 0; i < NSLOT; i++)
            if (!live[i]) return i;
        for (int i = 0; i < NSLOT; i++)
            if (w < 0 || t_sig[i] < t_sig[w]) w = i;
        return w;
    endfunction

    function out_t table_update(in_t q);
        out_t r;
        int sel;
        logic hit;
        logic [31:0] age;
        int n;
        sel = -1;
        hit = 1'b0;
        n = 0;
        case (op_t'(q.operation))
            OP_BEACON, OP_ANNOUNCE: begin
                sel = lookup(q.node_key);
                if (sel >= 0) begin
                    t_pics[sel] = q.picture_count;
                    t_seen[sel] = q.time_now_ms;
                    if (op_t'(q.operation) == OP_BEACON) begin
                        t_role[sel] = q.node_role;
                        if (q.signal_dbm > t_sig[sel]) t_sig[sel] = q.signal_dbm;
                    end else begin
                        t_ip[sel] = q.ip_addr;
                        picked[sel] = 1'b0;
                    end
                end else begin
                    sel = pick_victim();
                    hit = 1'b1;
                    t_key[sel] = q.node_key;
                    t_role[sel] = (op_t'(q.operation) == OP_BEACON) ? q.node_role : leaf_code;
                    t_pics[sel] = q.picture_count;
                    t_sig[sel] = (op_t'(q.operation) == OP_BEACON) ? q.signal_dbm : 8'sd0;
                    t_seen[sel] = q.time_now_ms;
                    picked[sel] = 1'b0;
                    live[sel] = 1'b1;
                    t_ip[sel] = (op_t'(q.operation) == OP_BEACON) ? 32'd0 : q.ip_addr;
                    t_hops[sel] = 8'd1;
                    t_rte[sel] = 1'b0;
                    t_relay[sel] = '0;
                end
            end
            OP_ROUTE: begin
                sel = lookup(q.node_key);
                if (sel >= 0) begin
                    hit = 1'b1;
                    t_hops[sel] = q.hops;
                    t_rte[sel] = 1'b1;
                    t_relay[sel] = q.relay_key;
                end
            end
            OP_MARK: begin
                sel = lookup(q.node_key);
                if (sel >= 0) begin
                    hit = 1'b1;
                    picked[sel] = 1'b1;
                end
            end
            OP_EXPIRE: begin
                for (int i = 0; i < NSLOT; i++) begin
                    age = q.time_now_ms - t_seen[i];
                    if (live[i] && age > age_limit) live[i] = 1'b0;
                end
            end
            OP_CLR_MARK: for (int i = 0; i < NSLOT; i++) picked[i] = 1'b0;
            OP_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) begin
                    live[i] = 1'b0; picked[i] = 1'b0; t_rte[i] = 1'b0; t_hops[i] = '0;
                    t_pics[i] = '0; t_sig[i] = -8'sd128; t_seen[i] = '0;
                    t_key[i] = '0; t_relay[i] = '0;
                end
            end
            OP_HARVEST: begin
                for (int i = 0; i < NSLOT; i++)
                    if (live[i] && !picked[i] && (sel < 0 || t_sig[i] > t_sig[sel])) sel = i;
                hit = (sel >= 0);
            end
            OP_LEAF: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (live[i] && t_role[i] == leaf_code) begin
                        if (sel < 0 || t_sig[i] > t_sig[sel]) sel = i;
                        else if (t_sig[i] == t_sig[sel] && t_key[i] > t_key[sel]) sel = i;
                    end
                end
                hit = (sel >= 0);
            end
            OP_MULTIHOP: begin
                sel = lookup(q.node_key);
                if (sel >= 0) hit = t_rte[sel] && (t_hops[sel] > 8'd1);
            end
            OP_READ: begin
                if (live[q.slot_select]) begin
                    sel = int'(q.slot_select);
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        r = '0;
        r.ok = hit;
        if (sel >= 0) begin
            r.slot = sel[3:0];
            r.out_key = t_key[sel];
            r.out_role = t_role[sel];
            r.out_pictures = t_pics[sel];
            r.out_signal = t_sig[sel];
            r.out_ip = t_ip[sel];
            r.out_hops = t_hops[sel];
            r.out_relay = t_relay[sel];
            r.out_route_known = t_rte[sel];
            r.out_harvested = picked[sel];
        end
        for (int i = 0; i < NSLOT; i++) n += live[i];
        r.live_count = n[4:0];
        return r;
    endfunction

    function void report(string what, out_t want, out_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s\n  exp %p\n  got %p", what, want, got);
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            table_reset();
            expected_results.delete();
            fail_count = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("result with no request pending", '0, m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.ok !== want.ok || m_data.slot !== want.slot ||
                        m_data.out_key !== want.out_key || m_data.out_role !== want.out_role ||
                        m_data.out_pictures !== want.out_pictures ||
                        m_data.out_signal !== want.out_signal || m_data.out_ip !== want.out_ip ||
                        m_data.out_hops !== want.out_hops || m_data.out_relay !== want.out_relay ||
                        m_data.out_route_known !== want.out_route_known ||
                        m_data.out_harvested !== want.out_harvested ||
                        m_data.live_count !== want.live_count)
                        report("result fields differ", want, m_data);
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_EXPIRY) age_limit = cfg_wdata;
                else if (cfg_index == CFG_LEAF) leaf_code = cfg_wdata[7:0];
            end
            if (s_valid && s_ready) expected_results.push_back(table_update(s_data));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the neighbor table regression: clock, reset, stimulus and verdict.
module tb;
    import nbt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;     // a little over the sweep latency
    localparam int PHASE_ITEMS = 206;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b1;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_EXPIRY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int   fail_count;
    int   outstanding;
    int   cycles = 0;
    bit   calm = 1'b0;          // no idling on either side once set
    int   stall_left = 0;
    logic [7:0]  leaf_now = LEAF_RESET;
    logic [31:0] clock_ms = 32'hFFFF_F000;
    logic [47:0] key_pool[24];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    neighbor_table_rssi_replace_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    nbt_checker i_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // Hard stop: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side back-pressure: drop ready for bursts of random length.
    always @(negedge aclk) begin
        if (calm) begin
            m_ready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready = (stall_left == 0);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Present one request, hold it until accepted, then maybe idle a burst.
    task automatic send_request(in_t req);
        s_data = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    // Write one register with the block idle: drain, then let it settle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_LEAF) leaf_now = val[7:0];
    endtask

    function automatic in_t make_req(op_t op, logic [47:0] key, logic [7:0] role,
                                     logic signed [7:0] sig, logic [31:0] now);
        in_t r;
        r = '0;
        r.operation = op;
        r.node_key = key;
        r.node_role = role;
        r.signal_dbm = sig;
        r.time_now_ms = now;
        r.picture_count = 8'($urandom);
        r.ip_addr = $urandom;
        r.relay_key = 48'({$urandom, $urandom});
        r.hops = 8'($urandom);
        r.slot_select = 4'($urandom);
        return r;
    endfunction

    // Mostly well-formed traffic over a small key pool so the table fills,
    // refreshes and replaces; a few stray keys and clock jumps for noise.
    function automatic in_t random_req();
        in_t r;
        int pct;
        op_t op;
        pct = $urandom_range(0, 99);
        if      (pct < 30) op = OP_BEACON;
        else if (pct < 44) op = OP_ANNOUNCE;
        else if (pct < 54) op = OP_ROUTE;
        else if (pct < 62) op = OP_MARK;
        else if (pct < 67) op = OP_EXPIRE;
        else if (pct < 70) op = OP_CLR_MARK;
        else if (pct < 71) op = OP_CLEAR;
        else if (pct < 78) op = OP_HARVEST;
        else if (pct < 85) op = OP_LEAF;
        else if (pct < 91) op = OP_MULTIHOP;
        else if (pct < 94) op = OP_COUNT;
        else               op = OP_READ;
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 3000);
        r = make_req(op, key_pool[$urandom_range(0, 23)],
                     $urandom_range(0, 1) ? leaf_now : 8'($urandom), 8'($urandom), clock_ms);
        if ($urandom_range(0, 19) == 0) r.node_key = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) r.hops = 8'($urandom_range(0, 2));
        return r;
    endfunction

    initial begin
        logic [47:0] kmax;
        logic [31:0] t0;
        kmax = '1;
        t0 = clock_ms;
        foreach (key_pool[i]) key_pool[i] = 48'({$urandom, $urandom});
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        write_reg(CFG_EXPIRY, EXPIRY_RESET);
        write_reg(CFG_LEAF, 32'(LEAF_RESET));

        // Directed: empty table, extremes, every operation, wrapped expiry.
        send_request(make_req(OP_COUNT, '0, '0, '0, t0));
        send_request(make_req(OP_READ, '0, '0, '0, t0));
        send_request(make_req(OP_BEACON, kmax, 8'd0, 8'sd127, t0));
        send_request(make_req(OP_BEACON, '0, 8'hFF, -8'sd128, t0));
        send_request(make_req(OP_BEACON, kmax, 8'd0, -8'sd5, t0 + 10));  // keeps the max
        send_request(make_req(OP_ANNOUNCE, '0, '0, '0, t0 + 20));
        send_request(make_req(OP_ANNOUNCE, 48'h1234_5678_9ABC, '0, '0, t0 + 20));
        s_data.hops = 8'hFF;
        send_request(make_req(OP_ROUTE, kmax, '0, '0, t0));
        send_request(make_req(OP_ROUTE, 48'h0000_0000_0042, '0, '0, t0));
        send_request(make_req(OP_MULTIHOP, kmax, '0, '0, t0));
        send_request(make_req(OP_MULTIHOP, '0, '0, '0, t0));
        send_request(make_req(OP_MARK, kmax, '0, '0, t0));
        send_request(make_req(OP_HARVEST, '0, '0, '0, t0));
        send_request(make_req(OP_CLR_MARK, '0, '0, '0, t0));
        send_request(make_req(OP_LEAF, '0, '0, '0, t0));
        // equal leaf signal: the higher node id must win
        send_request(make_req(OP_BEACON, 48'h5, 8'd0, 8'sd127, t0 + 30));
        send_request(make_req(OP_LEAF, '0, '0, '0, t0));
        send_request(make_req(OP_READ, '0, '0, '0, t0));
        send_request(make_req(OP_EXPIRE, '0, '0, '0, t0 + 60021));  // wraps the clock
        send_request(make_req(OP_COUNT, '0, '0, '0, t0));
        send_request(make_req(OP_CLEAR, '0, '0, '0, t0));
        send_request(make_req(OP_READ, '0, '0, '0, t0));
        send_request(make_req(OP_BEACON, kmax, 8'h55, 8'sd0, t0));

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin write_reg(CFG_EXPIRY, 32'd0);          write_reg(CFG_LEAF, 32'hFF); end
                2: begin write_reg(CFG_EXPIRY, 32'hFFFF_FFFF); write_reg(CFG_LEAF, 32'h5A); end
                3: begin write_reg(CFG_EXPIRY, 32'd5000);       write_reg(CFG_LEAF, $urandom); end
                4: begin write_reg(CFG_EXPIRY, $urandom_range(1000, 20000));
                         write_reg(CFG_LEAF, 32'd0); calm = 1'b1; end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_req());
        end

        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== neighbor_table_rssi_replace_core.f =====
hw/rtl/nbt_pkg.sv
hw/rtl/nbt_ram.sv
hw/rtl/nbt_scan.sv
hw/rtl/neighbor_table_rssi_replace_core.sv
test/nbt_checker.sv
test/tb.sv
